// ----- rtl/srs_pkg.sv -----
// Shared types, codes and constants of the servo recipe sequencer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
package srs_pkg;

  // Default sizes
  localparam int unsigned SRS_RECIPE_DEPTH = 32;
  localparam int unsigned SRS_SERVO_COUNT  = 2;

  // Fixed field widths
  localparam int unsigned POS_W    = 3;
  localparam int unsigned RUN_W    = 3;
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned WORD_W   = 8;
  localparam int unsigned PULSE_W  = 8;
  localparam int unsigned DELAY_W  = 6;
  localparam int unsigned LCNT_W   = 5;
  localparam int unsigned CFG_AW   = 3;
  localparam int unsigned IN_DW    = 24;
  localparam int unsigned OUT_DW   = 32;
  localparam int unsigned POS_COUNT = 6;

  // Request kinds carried in tuser
  localparam logic [REQ_W-1:0] REQ_TICK = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CMD  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LOAD = 2'd2;

  // User commands
  localparam logic [CMD_W-1:0] USR_NONE     = 3'd0;
  localparam logic [CMD_W-1:0] USR_PAUSE    = 3'd1;
  localparam logic [CMD_W-1:0] USR_LEFT     = 3'd2;
  localparam logic [CMD_W-1:0] USR_RIGHT    = 3'd3;
  localparam logic [CMD_W-1:0] USR_BEGIN    = 3'd4;
  localparam logic [CMD_W-1:0] USR_CONTINUE = 3'd5;
  localparam logic [CMD_W-1:0] USR_ERROR    = 3'd6;
  localparam logic [CMD_W-1:0] USR_CLEAR    = 3'd7;

  // Run states
  localparam logic [RUN_W-1:0] RUN_IDLE    = 3'd0;
  localparam logic [RUN_W-1:0] RUN_PAUSED  = 3'd1;
  localparam logic [RUN_W-1:0] RUN_RUNNING = 3'd2;
  localparam logic [RUN_W-1:0] RUN_ENDED   = 3'd3;
  localparam logic [RUN_W-1:0] RUN_ERROR   = 3'd4;

  // Recipe opcodes
  localparam logic [2:0] OP_END      = 3'd0;
  localparam logic [2:0] OP_MOV      = 3'd1;
  localparam logic [2:0] OP_WAIT     = 3'd2;
  localparam logic [2:0] OP_LOOP     = 3'd3;
  localparam logic [2:0] OP_END_LOOP = 3'd5;

  // LED bits
  localparam logic [1:0] LED_OFF   = 2'b00;
  localparam logic [1:0] LED_GREEN = 2'b01;
  localparam logic [1:0] LED_RED   = 2'b10;
  localparam logic [1:0] LED_BOTH  = 2'b11;

  localparam logic [POS_W-1:0]   POS_MAX     = 3'd5;
  localparam logic [DELAY_W-1:0] NUDGE_DELAY = 6'd2;
  localparam logic [4:0]         PAR_MASK    = 5'h1F;

  localparam logic [PULSE_W-1:0] PULSE_RESET [POS_COUNT] = '{
    8'd4, 8'd7, 8'd10, 8'd13, 8'd16, 8'd20
  };

  typedef struct packed {
    logic       set;
    logic [1:0] val;
  } srs_led_evt_t;

  typedef struct packed {
    logic              tick;
    logic              cmd_en;
    logic [CMD_W-1:0]  cmd;
    logic              load_en;
    logic [ADDR_W-1:0] load_addr;
    logic [WORD_W-1:0] load_word;
  } srs_ctrl_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [RUN_W-1:0] run;
    srs_led_evt_t     led;
  } srs_status_t;

endpackage

// ----- rtl/srs_pulse_tab.sv -----
// Pulse width table: six configuration registers and the lookup per output lane.
// Depends on srs_pkg.
`timescale 1ns / 1ps
module srs_pulse_tab import srs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [CFG_AW-1:0]  cfg_addr_i,
  input  logic [PULSE_W-1:0] cfg_data_i,
  input  logic [POS_W-1:0]   pos_i   [2],
  output logic [PULSE_W-1:0] pulse_o [2]
);

  logic [PULSE_W-1:0] pulse_q [POS_COUNT];

  // Write a register; indexes past the table are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < POS_COUNT; i++) pulse_q[i] <= PULSE_RESET[i];
    end else if (cfg_valid_i && (32'(cfg_addr_i) < POS_COUNT)) begin
      pulse_q[cfg_addr_i] <= cfg_data_i;
    end
  end

  // Select the width for each lane; positions above five read as five
  always_comb begin
    for (int j = 0; j < 2; j++) begin
      unique case (pos_i[j])
        3'd0:    pulse_o[j] = pulse_q[0];
        3'd1:    pulse_o[j] = pulse_q[1];
        3'd2:    pulse_o[j] = pulse_q[2];
        3'd3:    pulse_o[j] = pulse_q[3];
        3'd4:    pulse_o[j] = pulse_q[4];
        default: pulse_o[j] = pulse_q[5];
      endcase
    end
  end

endmodule

// ----- rtl/srs_servo.sv -----
// One servo channel: recipe memory, program state and the tick/command update.
// Depends on srs_pkg.
`timescale 1ns / 1ps
module srs_servo import srs_pkg::*; #(
  parameter int unsigned RECIPE_DEPTH = SRS_RECIPE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  srs_ctrl_t   ctrl_i,
  output srs_status_t status_o
);

  localparam int unsigned PcW = $clog2(RECIPE_DEPTH);
  localparam logic [PcW-1:0] PcLast = PcW'(RECIPE_DEPTH - 1);

  logic [POS_W-1:0]   pos_q, pos_d;
  logic [RUN_W-1:0]   run_q, run_d;
  logic [PcW-1:0]     pc_q, pc_d, pc_nxt;
  logic [PcW-1:0]     lstart_q, lstart_d;
  logic [LCNT_W-1:0]  lrem_q, lrem_d;
  logic               lact_q, lact_d;
  logic [DELAY_W-1:0] delay_q, delay_d;
  srs_led_evt_t       led_evt;

  logic [WORD_W-1:0]  recipe_mem [RECIPE_DEPTH];
  logic [WORD_W-1:0]  word_q;
  logic               mem_we;
  logic [PcW-1:0]     mem_wa;
  logic [2:0]         op;
  logic [4:0]         par;
  logic [POS_W-1:0]   span;

  assign op     = word_q[7:5];
  assign par    = word_q[4:0] & PAR_MASK;
  assign pc_nxt = (pc_q == PcLast) ? '0 : pc_q + 1'b1;
  assign span   = (par[2:0] > pos_q) ? (par[2:0] - pos_q) : (pos_q - par[2:0]);

  // Execute a tick or a command against the current state
  always_comb begin
    pos_d    = pos_q;
    run_d    = run_q;
    pc_d     = pc_q;
    lstart_d = lstart_q;
    lrem_d   = lrem_q;
    lact_d   = lact_q;
    delay_d  = delay_q;
    led_evt  = '0;
    if (ctrl_i.tick) begin
      if (delay_q != '0) begin
        delay_d = delay_q - 1'b1;
      end else if (run_q == RUN_RUNNING) begin
        led_evt = '{set: 1'b1, val: LED_GREEN};
        unique case (op)
          OP_END: begin
            pc_d   = '0;
            run_d  = RUN_ENDED;
            lact_d = 1'b0;
          end
          OP_MOV: begin
            if (par <= {2'b00, POS_MAX}) begin
              delay_d = {2'b00, span, 1'b0};
              pos_d   = par[2:0];
            end
            pc_d = pc_nxt;
          end
          OP_WAIT: begin
            delay_d = {1'b0, par} + 1'b1;
            pc_d    = pc_nxt;
          end
          OP_LOOP: begin
            if (lact_q) begin
              // nested loop: abort the recipe
              run_d    = RUN_ERROR;
              pc_d     = '0;
              lstart_d = '0;
              lrem_d   = '0;
              lact_d   = 1'b0;
              led_evt  = '{set: 1'b1, val: LED_BOTH};
            end else begin
              lact_d   = 1'b1;
              lstart_d = pc_nxt;
              lrem_d   = par;
              pc_d     = pc_nxt;
            end
          end
          OP_END_LOOP: begin
            if (lrem_q != '0) begin
              lrem_d = lrem_q - 1'b1;
              pc_d   = lstart_q;
            end else begin
              lact_d = 1'b0;
              pc_d   = pc_nxt;
            end
          end
          default: pc_d = pc_nxt;
        endcase
      end
    end else if (ctrl_i.cmd_en) begin
      unique case (ctrl_i.cmd)
        USR_NONE: run_d = RUN_IDLE;
        USR_PAUSE: begin
          run_d   = RUN_PAUSED;
          led_evt = '{set: 1'b1, val: LED_OFF};
        end
        USR_LEFT: begin
          if (pos_q < POS_MAX && run_q == RUN_PAUSED) begin
            pos_d   = pos_q + 1'b1;
            delay_d = NUDGE_DELAY;
          end
        end
        USR_RIGHT: begin
          if (pos_q != '0 && run_q == RUN_PAUSED) begin
            pos_d   = pos_q - 1'b1;
            delay_d = NUDGE_DELAY;
          end
        end
        USR_BEGIN: begin
          run_d = RUN_RUNNING;
          pc_d  = '0;
        end
        USR_CONTINUE: run_d = RUN_RUNNING;
        USR_ERROR:    led_evt = '{set: 1'b1, val: LED_RED};
        USR_CLEAR: begin
          pc_d  = '0;
          run_d = RUN_IDLE;
        end
        default: run_d = run_q;
      endcase
    end
  end

  // Hold the program state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      run_q    <= RUN_PAUSED;
      pc_q     <= '0;
      lstart_q <= '0;
      lrem_q   <= '0;
      lact_q   <= 1'b0;
      delay_q  <= '0;
    end else begin
      pos_q    <= pos_d;
      run_q    <= run_d;
      pc_q     <= pc_d;
      lstart_q <= lstart_d;
      lrem_q   <= lrem_d;
      lact_q   <= lact_d;
      delay_q  <= delay_d;
    end
  end

  // Recipe memory: write a loaded word, prefetch the word at the next pc
  assign mem_we = ctrl_i.load_en && (32'(ctrl_i.load_addr) < RECIPE_DEPTH);
  assign mem_wa = PcW'(ctrl_i.load_addr);

  always_ff @(posedge clk_i) begin
    if (mem_we) recipe_mem[mem_wa] <= ctrl_i.load_word;
    if (mem_we && mem_wa == pc_d) begin
      word_q <= ctrl_i.load_word;
    end else begin
      word_q <= recipe_mem[pc_d];
    end
  end

  assign status_o = '{pos: pos_d, run: run_d, led: led_evt};

  // Checks
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_MAX) else $error("servo position out of range");

  a_delay_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    delay_q <= 6'd32) else $error("delay count beyond longest wait");

  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_d == RUN_ERROR && run_q != RUN_ERROR) |=> (pc_q == '0 && !lact_q && lrem_q == '0))
    else $error("error entry left loop state behind");

  a_loop_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.tick && delay_q == '0 && run_q == RUN_RUNNING && op == OP_LOOP && !lact_q)
    |=> (lact_q && pc_q == lstart_q)) else $error("loop entry did not set loop start");

endmodule

// ----- rtl/servo_recipe_sequencer.sv -----
// Top level of the servo recipe sequencer: input word register, servo channels,
// pulse table and result register. Depends on srs_pkg, srs_servo, srs_pulse_tab.
// Path: a word waits in the input register, then its result is registered.
// Throughput: one word per cycle while results are taken; a held-off result keeps
//   one more word in the input register, after which the input stalls.
// Reset: servos paused at position 0, pc 0, no loop, LEDs off, pulse table at
//   defaults; the recipe memory is not cleared and no reset pass is needed.
`timescale 1ns / 1ps
module servo_recipe_sequencer import srs_pkg::*; #(
  parameter int unsigned RECIPE_DEPTH = SRS_RECIPE_DEPTH,
  parameter int unsigned SERVO_COUNT  = SRS_SERVO_COUNT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // tdata: load_servo, load_addr[4:0], load_word[7:0], cmd_first[2:0],
  //        cmd_second[2:0], zero pad [23:20]
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [IN_DW-1:0]   s_axis_tdata,
  // tuser: req_type[1:0]
  input  logic [REQ_W-1:0]   s_axis_tuser,
  // tdata: pulse_first[7:0], pulse_second[7:0], position_first[2:0],
  //        position_second[2:0], run_first[2:0], run_second[2:0], green_led,
  //        red_led, zero pad [31:30]
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [OUT_DW-1:0]  m_axis_tdata,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CFG_AW-1:0]  cfg_addr_i,
  input  logic [PULSE_W-1:0] cfg_data_i
);

  logic               in_valid_q;
  logic [REQ_W-1:0]   in_req_q;
  logic [IN_DW-1:0]   in_data_q;
  logic               advance;
  logic               out_valid_q;
  logic [OUT_DW-1:0]  out_data_q, out_data_d;
  logic [1:0]         led_q, led_d;

  logic               ld_servo;
  logic [ADDR_W-1:0]  ld_addr;
  logic [WORD_W-1:0]  ld_word;
  logic [CMD_W-1:0]   cmd_a, cmd_b;

  srs_ctrl_t          ctrl   [SERVO_COUNT];
  srs_status_t        status [SERVO_COUNT];
  logic [POS_W-1:0]   pos_w   [2];
  logic [RUN_W-1:0]   run_w   [2];
  logic [PULSE_W-1:0] lk_w    [2];
  logic [PULSE_W-1:0] pulse_w [2];

  // Step the held word once the result register can take its result
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_req_q  <= s_axis_tuser;
      in_data_q <= s_axis_tdata;
    end
  end

  // Unpack the held word
  assign ld_servo = in_data_q[0];
  assign ld_addr  = in_data_q[5:1];
  assign ld_word  = in_data_q[13:6];
  assign cmd_a    = in_data_q[16:14];
  assign cmd_b    = in_data_q[19:17];

  // Servo channels
  for (genvar s = 0; s < SERVO_COUNT; s++) begin : g_servo
    assign ctrl[s].tick      = advance && (in_req_q == REQ_TICK);
    assign ctrl[s].cmd_en    = advance && (in_req_q == REQ_CMD) && (s < 2);
    assign ctrl[s].cmd       = (s == 0) ? cmd_a : cmd_b;
    assign ctrl[s].load_en   = advance && (in_req_q == REQ_LOAD) && (32'(ld_servo) == s);
    assign ctrl[s].load_addr = ld_addr;
    assign ctrl[s].load_word = ld_word;

    srs_servo #(
      .RECIPE_DEPTH(RECIPE_DEPTH)
    ) u_servo (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl[s]),
      .status_o (status[s])
    );
  end

  // Result lanes; a missing servo reads as zero
  for (genvar j = 0; j < 2; j++) begin : g_lane
    if (j < SERVO_COUNT) begin : g_real
      assign pos_w[j]   = status[j].pos;
      assign run_w[j]   = status[j].run;
      assign pulse_w[j] = lk_w[j];
    end else begin : g_none
      assign pos_w[j]   = '0;
      assign run_w[j]   = '0;
      assign pulse_w[j] = '0;
    end
  end

  srs_pulse_tab u_pulse_tab (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .pos_i       (pos_w),
    .pulse_o     (lk_w)
  );

  // LEDs: the last servo that touches them wins
  always_comb begin
    led_d = led_q;
    for (int s = 0; s < SERVO_COUNT; s++) begin
      if (status[s].led.set) led_d = status[s].led.val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_q <= LED_OFF;
    end else begin
      led_q <= led_d;
    end
  end

  // Pack and hold the result word
  assign out_data_d = {2'b00, led_d[1], led_d[0], run_w[1], run_w[0],
                       pos_w[1], pos_w[0], pulse_w[1], pulse_w[0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for the servo recipe sequencer: random and directed requests on
// the input stream, results predicted by a shadow model and checked word by word.
// Depends on srs_pkg and servo_recipe_sequencer.
`timescale 1ns / 1ps

import srs_pkg::*;

// Input fields as packed into s_axis_tdata, lowest bit last
typedef struct packed {
  logic [CMD_W-1:0]  cmd_second;
  logic [CMD_W-1:0]  cmd_first;
  logic [WORD_W-1:0] load_word;
  logic [ADDR_W-1:0] load_addr;
  logic              load_servo;
} request_fields_t;

// Result fields as packed into m_axis_tdata, lowest bit last
typedef struct packed {
  logic               red_led;
  logic               green_led;
  logic [RUN_W-1:0]   run_second;
  logic [RUN_W-1:0]   run_first;
  logic [POS_W-1:0]   position_second;
  logic [POS_W-1:0]   position_first;
  logic [PULSE_W-1:0] pulse_second;
  logic [PULSE_W-1:0] pulse_first;
} servo_status_t;

localparam int unsigned FIELDS_W = $bits(request_fields_t);
localparam int unsigned STATUS_W = $bits(servo_status_t);

// Shadow copy of both servos; predicts one status word per accepted request
class servo_scoreboard;
  logic [PULSE_W-1:0] pos_pulse [POS_COUNT];
  logic [WORD_W-1:0]  recipe [SRS_SERVO_COUNT][SRS_RECIPE_DEPTH];
  bit                 written [SRS_SERVO_COUNT][SRS_RECIPE_DEPTH];
  logic [POS_W-1:0]   position [SRS_SERVO_COUNT];
  logic [RUN_W-1:0]   run [SRS_SERVO_COUNT];
  logic [ADDR_W-1:0]  pc [SRS_SERVO_COUNT];
  logic [ADDR_W-1:0]  loop_start [SRS_SERVO_COUNT];
  logic [LCNT_W-1:0]  loop_left [SRS_SERVO_COUNT];
  bit                 loop_open [SRS_SERVO_COUNT];
  logic [DELAY_W-1:0] countdown [SRS_SERVO_COUNT];
  logic [1:0]         led;
  servo_status_t      expected_q [$];
  int                 errors;

  function new();
    for (int i = 0; i < POS_COUNT; i++) pos_pulse[i] = PULSE_RESET[i];
    for (int s = 0; s < SRS_SERVO_COUNT; s++) begin
      position[s]   = '0;
      run[s]        = RUN_PAUSED;
      pc[s]         = '0;
      loop_start[s] = '0;
      loop_left[s]  = '0;
      loop_open[s]  = 1'b0;
      countdown[s]  = '0;
      for (int a = 0; a < SRS_RECIPE_DEPTH; a++) written[s][a] = 1'b0;
    end
    led    = LED_OFF;
    errors = 0;
  endfunction

  function void write_pulse(int idx, logic [PULSE_W-1:0] width);
    pos_pulse[idx] = width;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // Report a running servo about to fetch a word that was never loaded
  function bit blank_fetch(output int servo, output int addr);
    servo = 0;
    addr  = 0;
    for (int s = 0; s < SRS_SERVO_COUNT; s++) begin
      if (countdown[s] == 0 && run[s] == RUN_RUNNING && !written[s][pc[s]]) begin
        servo = s;
        addr  = pc[s];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // One 100 ms tick for one servo: burn down the delay or execute a word
  function void advance_on_tick(int s);
    logic [WORD_W-1:0]  word;
    logic [2:0]         op;
    logic [4:0]         par;
    logic [ADDR_W-1:0]  nxt;
    logic [POS_W-1:0]   span;
    if (countdown[s] != 0) begin
      countdown[s] = countdown[s] - 1'b1;
      return;
    end
    if (run[s] != RUN_RUNNING) return;
    word = recipe[s][pc[s]];
    op   = word[7:5];
    par  = word[4:0];
    nxt  = pc[s] + 1'b1;  // wraps at the end of the recipe store
    led  = LED_GREEN;
    case (op)
      OP_END: begin
        pc[s]        = '0;
        run[s]       = RUN_ENDED;
        loop_open[s] = 1'b0;
      end
      OP_MOV: begin
        // positions above the last one are skipped without a delay
        if (par <= 5'(POS_MAX)) begin
          span = (par[2:0] > position[s]) ? par[2:0] - position[s] : position[s] - par[2:0];
          countdown[s] = {2'b00, span, 1'b0};
          position[s]  = par[2:0];
        end
        pc[s] = nxt;
      end
      OP_WAIT: begin
        countdown[s] = DELAY_W'(par) + 1'b1;
        pc[s]        = nxt;
      end
      OP_LOOP: begin
        if (loop_open[s]) begin
          // nested loop: drop into the error state, both LEDs on
          run[s]        = RUN_ERROR;
          pc[s]         = '0;
          loop_start[s] = '0;
          loop_left[s]  = '0;
          loop_open[s]  = 1'b0;
          led           = LED_BOTH;
        end else begin
          loop_open[s]  = 1'b1;
          loop_start[s] = nxt;
          loop_left[s]  = par;
          pc[s]         = nxt;
        end
      end
      OP_END_LOOP: begin
        if (loop_left[s] != 0) begin
          loop_left[s] = loop_left[s] - 1'b1;
          pc[s]        = loop_start[s];
        end else begin
          loop_open[s] = 1'b0;
          pc[s]        = nxt;
        end
      end
      default: pc[s] = nxt;
    endcase
  endfunction

  function void apply_command(int s, logic [CMD_W-1:0] cmd);
    case (cmd)
      USR_NONE: run[s] = RUN_IDLE;
      USR_PAUSE: begin
        run[s] = RUN_PAUSED;
        led    = LED_OFF;
      end
      USR_LEFT: begin
        if (position[s] < POS_MAX && run[s] == RUN_PAUSED) begin
          position[s]  = position[s] + 1'b1;
          countdown[s] = NUDGE_DELAY;
        end
      end
      USR_RIGHT: begin
        if (position[s] > 0 && run[s] == RUN_PAUSED) begin
          position[s]  = position[s] - 1'b1;
          countdown[s] = NUDGE_DELAY;
        end
      end
      USR_BEGIN: begin
        run[s] = RUN_RUNNING;
        pc[s]  = '0;
      end
      USR_CONTINUE: run[s] = RUN_RUNNING;
      USR_ERROR: led = LED_RED;
      default: begin
        pc[s]  = '0;
        run[s] = RUN_IDLE;
      end
    endcase
  endfunction

  // Update the shadow for an accepted request and queue the status it yields
  function void note_request(logic [REQ_W-1:0] req, request_fields_t f);
    servo_status_t st;
    case (req)
      REQ_TICK: for (int s = 0; s < SRS_SERVO_COUNT; s++) advance_on_tick(s);
      REQ_CMD: begin
        apply_command(0, f.cmd_first);
        apply_command(1, f.cmd_second);
      end
      REQ_LOAD: begin
        recipe[f.load_servo][f.load_addr]  = f.load_word;
        written[f.load_servo][f.load_addr] = 1'b1;
      end
      default: ;
    endcase
    st.pulse_first     = pos_pulse[position[0]];
    st.pulse_second    = pos_pulse[position[1]];
    st.position_first  = position[0];
    st.position_second = position[1];
    st.run_first       = run[0];
    st.run_second      = run[1];
    st.green_led       = led[0];
    st.red_led         = led[1];
    expected_q.push_back(st);
  endfunction

  function void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  function void check_result(logic [OUT_DW-1:0] data);
    servo_status_t got;
    servo_status_t want;
    got = data[STATUS_W-1:0];
    if (expected_q.size() == 0) begin
      $error("status word %h arrived with nothing expected", data);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    compare_field("pulse_first", want.pulse_first, got.pulse_first);
    compare_field("pulse_second", want.pulse_second, got.pulse_second);
    compare_field("position_first", want.position_first, got.position_first);
    compare_field("position_second", want.position_second, got.position_second);
    compare_field("run_first", want.run_first, got.run_first);
    compare_field("run_second", want.run_second, got.run_second);
    compare_field("green_led", want.green_led, got.green_led);
    compare_field("red_led", want.red_led, got.red_led);
  endfunction
endclass

module tb;

  localparam int CLK_HALF        = 4;
  localparam int RESET_CYCLES    = 2;
  localparam int DRAIN_CYCLES    = 6;
  localparam int HOLD_CYCLES     = 120;
  localparam int BURST_ITEMS     = 24;
  localparam int ITEMS_PER_PHASE = 285;
  localparam int GAP_MAX         = 12;
  localparam longint RUN_LIMIT_NS = 5_000_000;

  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
  localparam logic [2:0] OP_NOP4 = 3'd4;
  localparam logic [2:0] OP_NOP6 = 3'd6;
  localparam logic [2:0] OP_NOP7 = 3'd7;

  typedef enum int {PULSE_ZERO, PULSE_FULL, PULSE_ALTERNATE, PULSE_RANDOM} pulse_pattern_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [IN_DW-1:0]   s_axis_tdata = '0;
  logic [REQ_W-1:0]   s_axis_tuser = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [OUT_DW-1:0]  m_axis_tdata;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CFG_AW-1:0]  cfg_addr = '0;
  logic [PULSE_W-1:0] cfg_data = '0;

  servo_scoreboard shadow;
  int  items_sent = 0;
  int  tx_gap_max = 0;
  int  rx_gap_max = 0;
  int  hold_requests = 0;

  always #CLK_HALF clk_i = ~clk_i;

  servo_recipe_sequencer uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_addr_i   (cfg_addr),
    .cfg_data_i   (cfg_data)
  );

  function automatic request_fields_t load_fields(int servo, int addr, logic [WORD_W-1:0] word);
    request_fields_t f;
    f            = '0;
    f.load_servo = servo[0];
    f.load_addr  = addr[ADDR_W-1:0];
    f.load_word  = word;
    return f;
  endfunction

  function automatic request_fields_t cmd_fields(logic [CMD_W-1:0] first, logic [CMD_W-1:0] second);
    request_fields_t f;
    f            = '0;
    f.cmd_first  = first;
    f.cmd_second = second;
    return f;
  endfunction

  function automatic request_fields_t random_fields();
    logic [FIELDS_W-1:0] bits;
    bits = FIELDS_W'($urandom);
    return request_fields_t'(bits);
  endfunction

  // Mostly short moves, waits and loops so that recipes finish within an episode
  function automatic logic [WORD_W-1:0] random_recipe_word();
    int         pick;
    logic [2:0] op;
    logic [4:0] par;
    pick = $urandom_range(99, 0);
    par  = 5'($urandom_range(3, 0));
    if (pick < 30) begin
      op  = OP_MOV;
      par = (pick < 3) ? 5'($urandom_range(31, 6)) : 5'($urandom_range(5, 0));
    end else if (pick < 50) begin
      op = OP_WAIT;
      if (pick < 32) par = 5'($urandom);
    end else if (pick < 65) begin
      op = OP_LOOP;
    end else if (pick < 85) begin
      op = OP_END_LOOP;
    end else begin
      op  = 3'($urandom_range(7, 4));
      par = 5'($urandom);
    end
    return {op, par};
  endfunction

  // Offer one word after a random gap and hold it until accepted
  task automatic send_request(input logic [REQ_W-1:0] req, input request_fields_t f);
    int gap;
    int s;
    int a;
    gap = (tx_gap_max == 0) ? 0 : $urandom_range(tx_gap_max, 0);
    // never let a running servo fetch an empty recipe slot: fill it first
    if (req == REQ_TICK && shadow.blank_fetch(s, a)) begin
      req = REQ_LOAD;
      f   = load_fields(s, a, WORD_W'($urandom));
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= IN_DW'(f);
    do @(posedge clk_i); while (!s_axis_tready);
    shadow.note_request(req, f);
    items_sent++;
  endtask

  // Drop valid and wait until every expected status word has come back
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_pulse_table(input pulse_pattern_t pattern);
    logic [PULSE_W-1:0] width;
    for (int i = 0; i < POS_COUNT; i++) begin
      case (pattern)
        PULSE_ZERO:      width = '0;
        PULSE_FULL:      width = '1;
        PULSE_ALTERNATE: width = i[0] ? '1 : '0;
        default:         width = PULSE_W'($urandom);
      endcase
      cfg_valid <= 1'b1;
      cfg_addr  <= CFG_AW'(i);
      cfg_data  <= width;
      do @(posedge clk_i); while (!cfg_ready);
      shadow.write_pulse(i, width);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic directed_checks();
    tx_gap_max = 0;
    rx_gap_max = 0;
    // paused after reset: a tick changes nothing
    send_request(REQ_TICK, '0);
    // nudge below zero saturates, then walk both up, servo 0 saturates at five
    send_request(REQ_CMD, cmd_fields(USR_RIGHT, USR_RIGHT));
    repeat (5) send_request(REQ_CMD, cmd_fields(USR_LEFT, USR_LEFT));
    send_request(REQ_CMD, cmd_fields(USR_LEFT, USR_RIGHT));
    // the second servo's command decides the LEDs
    send_request(REQ_CMD, cmd_fields(USR_ERROR, USR_PAUSE));
    send_request(REQ_CMD, cmd_fields(USR_PAUSE, USR_ERROR));
    send_request(REQ_UNKNOWN, random_fields());
    // servo 0: nested loop; servo 1: move out of range, spare opcodes, stray loop end
    send_request(REQ_LOAD, load_fields(0, 0, {OP_LOOP, 5'd1}));
    send_request(REQ_LOAD, load_fields(0, 1, {OP_LOOP, 5'd0}));
    send_request(REQ_LOAD, load_fields(1, 0, {OP_MOV, 5'd7}));
    send_request(REQ_LOAD, load_fields(1, 1, {OP_NOP4, 5'h1F}));
    send_request(REQ_LOAD, load_fields(1, 2, {OP_END_LOOP, 5'd0}));
    send_request(REQ_LOAD, load_fields(1, 3, {OP_WAIT, 5'd0}));
    send_request(REQ_LOAD, load_fields(1, 4, {OP_NOP6, 5'd0}));
    send_request(REQ_LOAD, load_fields(1, 5, {OP_NOP7, 5'h1F}));
    send_request(REQ_LOAD, load_fields(1, 6, {OP_END, 5'd0}));
    send_request(REQ_CMD, cmd_fields(USR_BEGIN, USR_CONTINUE));
    // the first two ticks only run down the nudge delay
    repeat (4) send_request(REQ_TICK, '0);
    send_request(REQ_CMD, cmd_fields(USR_CLEAR, USR_NONE));
  endtask

  // Load, start and tick a short recipe in one or both servos, or send random words
  task automatic run_episode();
    int              pick;
    int              len;
    logic [1:0]      mask;
    request_fields_t f;
    pick       = $urandom_range(99, 0);
    tx_gap_max = $urandom_range(1, 0) ? GAP_MAX : 0;
    rx_gap_max = $urandom_range(1, 0) ? GAP_MAX : 0;
    if (pick < 20) begin
      repeat ($urandom_range(8, 3)) send_request(REQ_W'($urandom), random_fields());
      return;
    end
    mask = 2'($urandom_range(3, 1));
    for (int s = 0; s < SRS_SERVO_COUNT; s++) begin
      if (mask[s]) begin
        len = $urandom_range(9, 2);
        for (int a = 0; a < len; a++) send_request(REQ_LOAD, load_fields(s, a, random_recipe_word()));
        send_request(REQ_LOAD, load_fields(s, len,
                     ($urandom_range(9, 0) != 0) ? {OP_END, 5'd0} : WORD_W'($urandom)));
      end
    end
    f = cmd_fields(mask[0] ? USR_BEGIN : CMD_W'($urandom), mask[1] ? USR_BEGIN : CMD_W'($urandom));
    send_request(REQ_CMD, f);
    repeat ($urandom_range(40, 10)) begin
      pick = $urandom_range(99, 0);
      if (pick < 8)       send_request(REQ_CMD, cmd_fields(CMD_W'($urandom), CMD_W'($urandom)));
      else if (pick < 12) send_request(REQ_LOAD, random_fields());
      else                send_request(REQ_TICK, '0);
    end
  endtask

  // Keep offering words back to back while the result side holds off
  task automatic stall_output_burst();
    tx_gap_max = 0;
    hold_requests++;
    repeat (BURST_ITEMS) send_request(REQ_TICK, '0);
  endtask

  task automatic random_phase(input int count, input bit with_stall);
    int stop_at;
    stop_at = items_sent + count;
    if (with_stall) stall_output_burst();
    while (items_sent < stop_at) run_episode();
  endtask

  // Result side: check each accepted word, then draw the next stall
  initial begin
    int rx_wait;
    int hold_left;
    int holds_seen;
    rx_wait    = 0;
    hold_left  = 0;
    holds_seen = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        shadow.check_result(m_axis_tdata);
        rx_wait = (rx_gap_max == 0) ? 0 : $urandom_range(rx_gap_max, 0);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      if (hold_requests != holds_seen) begin
        hold_left  = HOLD_CYCLES;
        holds_seen = hold_requests;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      m_axis_tready <= (rx_wait == 0) && (hold_left == 0);
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    shadow = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_checks();
    wait_for_results();
    write_pulse_table(PULSE_ZERO);
    random_phase(ITEMS_PER_PHASE, 1'b0);
    wait_for_results();
    write_pulse_table(PULSE_FULL);
    random_phase(ITEMS_PER_PHASE, 1'b1);
    wait_for_results();
    write_pulse_table(PULSE_ALTERNATE);
    random_phase(ITEMS_PER_PHASE, 1'b0);
    wait_for_results();
    write_pulse_table(PULSE_RANDOM);
    random_phase(ITEMS_PER_PHASE, 1'b0);
    wait_for_results();
    if (shadow.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/srs_pkg.sv
rtl/srs_pulse_tab.sv
rtl/srs_servo.sv
rtl/servo_recipe_sequencer.sv
bench/tb.sv
